/* src/rfrt_pkg.sv */
`timescale 1ns / 1ps
// Shared types, register codes and fixed-point helpers for the ray frame transform.
// Depends on nothing; every other file of the block uses it.
package rfrt_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_COS    = 3'd1,
        REG_SIN    = 3'd2,
        REG_OFS_X  = 3'd3,
        REG_OFS_Y  = 3'd4,
        REG_OFS_Z  = 3'd5,
        REG_DIST   = 3'd6
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;

    // Transform modes.
    localparam logic MODE_PRIMARY   = 1'b0;
    localparam logic MODE_SECONDARY = 1'b1;

    // Reset value of the cosine: 1.0 in Q2.30.
    localparam logic signed [31:0] COS_RESET = 32'sh4000_0000;

    // Half of one Q16.16 step in the Q18.46 product domain.
    localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;

    // Saturation limits of a 32-bit word, held at the widest intermediate width.
    localparam logic signed [36:0] SAT_HI = 37'sd2147483647;
    localparam logic signed [36:0] SAT_LO = -(37'sd2147483648);

    // One input ray.
    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_in_t;

    // One transformed ray.
    typedef struct packed {
        logic signed [31:0] new_start_x;
        logic signed [31:0] new_start_y;
        logic signed [31:0] new_start_z;
        logic signed [31:0] new_dir_x;
        logic signed [31:0] new_dir_y;
        logic signed [31:0] new_dir_z;
    } ray_out_t;

    // Configuration register file contents.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] cos_angle;
        logic signed [31:0] sin_angle;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] source_distance;
    } cfg_t;

    // Products of the multiplier stage, Q18.46, plus terms that bypass it.
    typedef struct packed {
        logic signed [63:0] cy;
        logic signed [63:0] sz;
        logic signed [63:0] sy;
        logic signed [63:0] cz;
        logic signed [63:0] ca;
        logic signed [63:0] sb;
        logic signed [63:0] sc;
        logic signed [63:0] cd;
        logic signed [63:0] cdy;
        logic signed [63:0] sdz;
        logic signed [63:0] sdy;
        logic signed [63:0] cdz;
        logic signed [32:0] nx;
        logic signed [31:0] dx;
        logic signed [31:0] add_y;
        logic signed [31:0] add_z;
    } prod_t;

    // Exact sums of the adder stage, still Q18.46.
    typedef struct packed {
        logic signed [65:0] sum_y;
        logic signed [65:0] sum_z;
        logic signed [65:0] sum_dy;
        logic signed [65:0] sum_dz;
        logic signed [32:0] nx;
        logic signed [31:0] dx;
        logic signed [31:0] add_y;
        logic signed [31:0] add_z;
    } sum_t;

    // Round a Q18.46 sum half up to Q16.16 (floor of (v + 2^29) / 2^30).
    function automatic logic signed [35:0] round_q30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + ROUND_HALF;
        return t[65:30];
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_LO)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/rfrt_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file of the ray frame transform.
// Depends on rfrt_pkg for the register codes and the cfg_t layout.
module rfrt_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [rfrt_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [31:0]                     wr_data,
    output rfrt_pkg::cfg_t                  cfg
);

    rfrt_pkg::cfg_t cfg_reg;
    rfrt_pkg::cfg_t cfg_next;

    // Decode the write; an index beyond the list leaves everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                rfrt_pkg::REG_MODE:  cfg_next.mode            = wr_data[0];
                rfrt_pkg::REG_COS:   cfg_next.cos_angle       = wr_data;
                rfrt_pkg::REG_SIN:   cfg_next.sin_angle       = wr_data;
                rfrt_pkg::REG_OFS_X: cfg_next.offset_x        = wr_data;
                rfrt_pkg::REG_OFS_Y: cfg_next.offset_y        = wr_data;
                rfrt_pkg::REG_OFS_Z: cfg_next.offset_z        = wr_data;
                rfrt_pkg::REG_DIST:  cfg_next.source_distance = wr_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with its reset values (identity rotation, no offsets).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= rfrt_pkg::MODE_PRIMARY;
            cfg_reg.cos_angle       <= rfrt_pkg::COS_RESET;
            cfg_reg.sin_angle       <= '0;
            cfg_reg.offset_x        <= '0;
            cfg_reg.offset_y        <= '0;
            cfg_reg.offset_z        <= '0;
            cfg_reg.source_distance <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/rfrt_mult_stage.sv */
`timescale 1ns / 1ps
// Multiplier stage: forms every Q16.16 x Q2.30 product of one ray and applies
// the secondary-mode ray filter. Depends on rfrt_pkg.
module rfrt_mult_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  rfrt_pkg::cfg_t    cfg,
    input  logic              up_valid,
    input  rfrt_pkg::ray_in_t up_data,
    output logic              up_take,
    output logic              valid,
    output rfrt_pkg::prod_t   data,
    input  logic              down_take
);

    logic              valid_reg;
    logic              valid_next;
    rfrt_pkg::prod_t   data_reg;
    rfrt_pkg::prod_t   data_next;
    logic              secondary;
    logic              keep;
    logic signed [31:0] term_a;
    logic signed [31:0] term_b;

    assign secondary = (cfg.mode == rfrt_pkg::MODE_SECONDARY);

    // In secondary mode a ray survives only when it starts at or above z = 0
    // and heads downward.
    assign keep = !secondary || (!up_data.start_z[31] && up_data.dir_z[31]);

    // The stage loads when it is empty or its content moves on.
    assign up_take = !valid_reg || down_take;

    // Constant terms: primary mode uses the source distance, secondary mode
    // subtracts the frame origin before the rotation.
    assign term_a = secondary ? cfg.offset_y : cfg.source_distance;
    assign term_b = secondary ? cfg.offset_z : 32'sd0;

    // Products and the terms that bypass the multipliers.
    always_comb
    begin
        data_next.cy  = cfg.cos_angle * up_data.start_y;
        data_next.sz  = cfg.sin_angle * up_data.start_z;
        data_next.sy  = cfg.sin_angle * up_data.start_y;
        data_next.cz  = cfg.cos_angle * up_data.start_z;
        data_next.ca  = cfg.cos_angle * term_a;
        data_next.sb  = cfg.sin_angle * term_b;
        data_next.sc  = cfg.sin_angle * term_a;
        data_next.cd  = cfg.cos_angle * term_b;
        data_next.cdy = cfg.cos_angle * up_data.dir_y;
        data_next.sdz = cfg.sin_angle * up_data.dir_z;
        data_next.sdy = cfg.sin_angle * up_data.dir_y;
        data_next.cdz = cfg.cos_angle * up_data.dir_z;
        if (secondary)
        begin
            data_next.nx    = 33'(up_data.start_x) - 33'(cfg.offset_x);
            data_next.add_y = 32'sd0;
            data_next.add_z = 32'sd0;
        end
        else
        begin
            data_next.nx    = 33'(up_data.start_x) + 33'(cfg.offset_x);
            data_next.add_y = cfg.offset_y;
            data_next.add_z = cfg.offset_z;
        end
        data_next.dx = up_data.dir_x;
    end

    assign valid_next = up_take ? (up_valid && keep) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* src/rfrt_sum_stage.sv */
`timescale 1ns / 1ps
// Adder stage: exact sums of the rotation products in Q18.46.
// Depends on rfrt_pkg.
module rfrt_sum_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  rfrt_pkg::prod_t up_data,
    output logic            up_take,
    output logic            valid,
    output rfrt_pkg::sum_t  data,
    input  logic            down_take
);

    logic           valid_reg;
    rfrt_pkg::sum_t data_reg;
    rfrt_pkg::sum_t data_next;

    assign up_take = !valid_reg || down_take;

    // y' = c*y - s*z - c*a + s*b and z' = s*y + c*z - s*a - c*b, where a and b
    // were chosen by mode in the multiplier stage.
    always_comb
    begin
        data_next.sum_y  = 66'(up_data.cy) - 66'(up_data.sz)
                         - 66'(up_data.ca) + 66'(up_data.sb);
        data_next.sum_z  = 66'(up_data.sy) + 66'(up_data.cz)
                         - 66'(up_data.sc) - 66'(up_data.cd);
        data_next.sum_dy = 66'(up_data.cdy) - 66'(up_data.sdz);
        data_next.sum_dz = 66'(up_data.sdy) + 66'(up_data.cdz);
        data_next.nx     = up_data.nx;
        data_next.dx     = up_data.dx;
        data_next.add_y  = up_data.add_y;
        data_next.add_z  = up_data.add_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* src/rfrt_out_stage.sv */
`timescale 1ns / 1ps
// Output stage: rounds the sums to Q16.16, adds the frame offsets, saturates
// and holds the result register. Depends on rfrt_pkg.
module rfrt_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  rfrt_pkg::sum_t     up_data,
    output logic               up_take,
    output logic               valid,
    output rfrt_pkg::ray_out_t data,
    input  logic               stall
);

    logic               valid_reg;
    rfrt_pkg::ray_out_t data_reg;
    rfrt_pkg::ray_out_t data_next;

    // The result register frees up when it is empty or its result is taken.
    assign up_take = !valid_reg || !stall;

    always_comb
    begin
        data_next.new_start_x = rfrt_pkg::sat32(37'(up_data.nx));
        data_next.new_start_y = rfrt_pkg::sat32(37'(rfrt_pkg::round_q30(up_data.sum_y))
                                                + 37'(up_data.add_y));
        data_next.new_start_z = rfrt_pkg::sat32(37'(rfrt_pkg::round_q30(up_data.sum_z))
                                                + 37'(up_data.add_z));
        data_next.new_dir_x   = up_data.dx;
        data_next.new_dir_y   = rfrt_pkg::sat32(37'(rfrt_pkg::round_q30(up_data.sum_dy)));
        data_next.new_dir_z   = rfrt_pkg::sat32(37'(rfrt_pkg::round_q30(up_data.sum_dz)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* src/ray_frame_rotate_translate.sv */
`timescale 1ns / 1ps
// Top level of the ray frame transform: rotation about x plus translation.
// Depends on rfrt_pkg, rfrt_cfg_regs, rfrt_mult_stage, rfrt_sum_stage, rfrt_out_stage.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall   in_data  (ray_in_t, one ray)
//   out      out_valid / out_stall out_data (ray_out_t, one ray in the new frame)
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// While the output is not stalled, one ray per cycle is accepted; each request
// passes through the input register, multiplier stage, adder stage and result
// register in turn. The multiplier stage forms all twelve products of a ray in
// parallel. Reset clears every valid bit and loads the identity
// transform. A stalled output holds the pipeline; empty stages still fill, so
// requests are taken while a result waits. Rays dropped by the filter leave a
// bubble and produce no result.
module ray_frame_rotate_translate (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rfrt_pkg::ray_in_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rfrt_pkg::ray_out_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rfrt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    rfrt_pkg::cfg_t     cfg;
    logic               s0_valid_reg;
    logic               s0_valid_next;
    rfrt_pkg::ray_in_t  s0_data_reg;
    logic               s0_take;
    logic               s1_take;
    logic               s1_valid;
    rfrt_pkg::prod_t    s1_data;
    logic               s2_take;
    logic               s2_valid;
    rfrt_pkg::sum_t     s2_data;
    logic               s3_take;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    rfrt_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Input register: takes a request when empty or when it hands its ray on.
    assign s0_take       = !s0_valid_reg || s1_take;
    assign in_stall      = !s0_take;
    assign s0_valid_next = s0_take ? in_valid : s0_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_take && in_valid)
        begin
            s0_data_reg <= in_data;
        end
    end

    rfrt_mult_stage u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .up_valid  (s0_valid_reg),
        .up_data   (s0_data_reg),
        .up_take   (s1_take),
        .valid     (s1_valid),
        .data      (s1_data),
        .down_take (s2_take)
    );

    rfrt_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s1_valid),
        .up_data   (s1_data),
        .up_take   (s2_take),
        .valid     (s2_valid),
        .data      (s2_data),
        .down_take (s3_take)
    );

    rfrt_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_data  (s2_data),
        .up_take  (s3_take),
        .valid    (out_valid),
        .data     (out_data),
        .stall    (out_stall)
    );

endmodule

/* test/ray_frame_rotate_translate_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ray_frame_rotate_translate: rays in, rays in the new frame out.
// A scoreboard class predicts each accepted request; depends on rfrt_pkg and the RTL.
module ray_frame_rotate_translate_tb;

    typedef logic signed [79:0] wide_t;

    localparam logic [2:0]  REG_NONE     = 3'd7;
    localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;
    localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
    localparam int          RAND_PHASES  = 6;
    localparam int          RAND_RAYS    = 175;
    localparam int          FLUSH_CYCLES = 20;
    localparam int          IDLE_PCT     = 35;

    // Keeps the register copy, predicts transformed rays and checks results in order.
    class ray_scoreboard;
        rfrt_pkg::cfg_t     regs;
        rfrt_pkg::ray_out_t expected_rays[$];
        int                 errors;

        function new();
            regs           = '0;
            regs.mode      = rfrt_pkg::MODE_PRIMARY;
            regs.cos_angle = rfrt_pkg::COS_RESET;
            errors         = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                rfrt_pkg::REG_MODE:  regs.mode            = val[0];
                rfrt_pkg::REG_COS:   regs.cos_angle       = val;
                rfrt_pkg::REG_SIN:   regs.sin_angle       = val;
                rfrt_pkg::REG_OFS_X: regs.offset_x        = val;
                rfrt_pkg::REG_OFS_Y: regs.offset_y        = val;
                rfrt_pkg::REG_OFS_Z: regs.offset_z        = val;
                rfrt_pkg::REG_DIST:  regs.source_distance = val;
                default: ;
            endcase
        endfunction

        // Floor of (v + 2^29) / 2^30: Q18.46 down to Q16.16, half rounds up.
        function wide_t round_q16(wide_t v);
            return (v + 80'sd536870912) >>> 30;
        endfunction

        function logic [31:0] clamp(wide_t v);
            if (v > 80'sh7FFF_FFFF)
            begin
                return Q_MAX;
            end
            if (v < -80'sh8000_0000)
            begin
                return Q_MIN;
            end
            return v[31:0];
        endfunction

        // Returns 0 when the secondary-mode filter drops the ray.
        function bit frame_transform(input rfrt_pkg::ray_in_t r,
                                     output rfrt_pkg::ray_out_t o);
            wide_t c, s, x0, y0, z0, d, x, y, z, dy, dz;
            c  = regs.cos_angle;
            s  = regs.sin_angle;
            x0 = regs.offset_x;
            y0 = regs.offset_y;
            z0 = regs.offset_z;
            d  = regs.source_distance;
            x  = r.start_x;
            y  = r.start_y;
            z  = r.start_z;
            dy = r.dir_y;
            dz = r.dir_z;
            o.new_dir_x = r.dir_x;
            o.new_dir_y = clamp(round_q16(c * dy - s * dz));
            o.new_dir_z = clamp(round_q16(s * dy + c * dz));
            if (regs.mode == rfrt_pkg::MODE_PRIMARY)
            begin
                o.new_start_x = clamp(x0 + x);
                o.new_start_y = clamp(y0 + round_q16(c * y - s * z - c * d));
                o.new_start_z = clamp(z0 + round_q16(s * y + c * z - s * d));
                return 1'b1;
            end
            // Secondary mode keeps only rays that start at or above z = 0 and head down.
            if (!(r.start_z >= 0 && r.dir_z < 0))
            begin
                return 1'b0;
            end
            o.new_start_x = clamp(x - x0);
            o.new_start_y = clamp(round_q16(c * y - c * y0 - s * z + s * z0));
            o.new_start_z = clamp(round_q16(s * y - s * y0 + c * z - c * z0));
            return 1'b1;
        endfunction

        function void note_ray(rfrt_pkg::ray_in_t r);
            rfrt_pkg::ray_out_t o;
            if (frame_transform(r, o))
            begin
                expected_rays.insert(expected_rays.size(), o);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: %s expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_ray(rfrt_pkg::ray_out_t got);
            rfrt_pkg::ray_out_t want;
            if (expected_rays.size() == 0)
            begin
                errors++;
                $display("%0t ns: result expected none, actual %h", $time, got);
                return;
            end
            want = expected_rays.pop_front();
            compare_field("new_start_x", want.new_start_x, got.new_start_x);
            compare_field("new_start_y", want.new_start_y, got.new_start_y);
            compare_field("new_start_z", want.new_start_z, got.new_start_z);
            compare_field("new_dir_x", want.new_dir_x, got.new_dir_x);
            compare_field("new_dir_y", want.new_dir_y, got.new_dir_y);
            compare_field("new_dir_z", want.new_dir_z, got.new_dir_z);
        endfunction

        function int pending();
            return expected_rays.size();
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    rfrt_pkg::ray_in_t                in_data;
    logic                             out_valid;
    logic                             out_stall;
    rfrt_pkg::ray_out_t               out_data;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rfrt_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                      cfg_data;

    ray_scoreboard sb = new();
    bit            in_calm;
    bit            out_calm;
    int            hold_cycles;
    int            phase;

    ray_frame_rotate_translate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Watch both channels: note accepted requests, check accepted results.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_ray(in_data);
            end
            if (out_valid === 1'b1 && !out_stall)
            begin
                sb.check_ray(out_data);
            end
        end
    end

    // Receiver: random stalls, calm stretches, and a long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                out_stall <= !out_calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return v;
            default: return {{12{v[19]}}, v[19:0]};
        endcase
    endfunction

    // Mostly within +-1.0, with the exact ends and now and then any 32-bit value.
    function automatic logic [31:0] random_coef();
        longint v;
        case ($urandom_range(0, 7))
            0: return Q30_ONE;
            1: return -Q30_ONE;
            2: return '0;
            3: return $urandom;
            default:
            begin
                v = longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824;
                return v[31:0];
            end
        endcase
    endfunction

    // In secondary mode most rays are shaped to pass the filter.
    function automatic rfrt_pkg::ray_in_t random_ray(bit filtered);
        rfrt_pkg::ray_in_t r;
        r.start_x = random_coord();
        r.start_y = random_coord();
        r.start_z = random_coord();
        r.dir_x   = random_coord();
        r.dir_y   = random_coord();
        r.dir_z   = random_coord();
        if (filtered && $urandom_range(0, 99) < 80)
        begin
            r.start_z[31] = 1'b0;
            r.dir_z[31]   = 1'b1;
        end
        return r;
    endfunction

    // Offer one request after a random gap; returns at the edge that takes it.
    task automatic send_ray(input rfrt_pkg::ray_in_t r);
        int gap;
        gap = 0;
        if (!in_calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                gap++;
            end
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic program_frame(input logic [31:0] mode_word, input logic [31:0] c,
                                 input logic [31:0] s, input logic [31:0] x0,
                                 input logic [31:0] y0, input logic [31:0] z0,
                                 input logic [31:0] d);
        write_reg(rfrt_pkg::REG_MODE, mode_word);
        write_reg(rfrt_pkg::REG_COS, c);
        write_reg(rfrt_pkg::REG_SIN, s);
        write_reg(rfrt_pkg::REG_OFS_X, x0);
        write_reg(rfrt_pkg::REG_OFS_Y, y0);
        write_reg(rfrt_pkg::REG_OFS_Z, z0);
        write_reg(rfrt_pkg::REG_DIST, d);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering, wait for every expected ray, then let dropped rays clear out.
    task automatic wait_frame_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] mode_word;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        hold_cycles = 0;
        rst_n       = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity transform from reset, extreme rays.
        send_ray(rfrt_pkg::ray_in_t'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_ray(rfrt_pkg::ray_in_t'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX});
        send_ray(rfrt_pkg::ray_in_t'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN});
        send_ray(rfrt_pkg::ray_in_t'{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN});
        wait_frame_idle();

        // Primary mode, c = 0.5 and s = -0.866: half-step rounding and x saturation.
        program_frame(32'd0, 32'h2000_0000, 32'hC893_0A2F, 32'h7FFF_0000,
                      32'hFFFF_0000, 32'h0003_0000, 32'h0005_0000);
        send_ray(rfrt_pkg::ray_in_t'{32'h0001_0000, 32'h1, 32'h0, Q_MAX, 32'h1, 32'h0});
        send_ray(rfrt_pkg::ray_in_t'{Q_MAX, 32'hFFFF_FFFF, 32'h0, Q_MIN,
                                     32'hFFFF_FFFF, 32'h0});
        send_ray(rfrt_pkg::ray_in_t'{Q_MIN, 32'h3, 32'h1, 32'h0, 32'h3, 32'hFFFF_FFFF});
        send_ray(rfrt_pkg::ray_in_t'{'1, '1, '1, '1, '1, '1});
        send_ray(rfrt_pkg::ray_in_t'{32'h0, Q_MAX, Q_MIN, 32'h1, Q_MIN, Q_MAX});
        wait_frame_idle();

        // Coefficients beyond +-1.0 with extreme offsets, to drive the sums into saturation.
        program_frame(32'd0, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MIN);
        send_ray(rfrt_pkg::ray_in_t'{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX});
        send_ray(rfrt_pkg::ray_in_t'{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN});
        send_ray(rfrt_pkg::ray_in_t'{Q_MIN, Q_MAX, Q_MIN, 32'h0, Q_MIN, Q_MAX});
        wait_frame_idle();

        // Secondary mode set by a word with high bits; a write to the unused index is ignored.
        program_frame(32'hFFFF_FFFF, Q30_ONE, 32'h0, 32'h0002_0000, 32'hFFFD_0000,
                      32'h0001_8000, 32'h1234_5678);
        @(posedge clk);
        write_reg(REG_NONE, 32'hDEAD_BEEF);
        cfg_valid <= 1'b0;
        send_ray(rfrt_pkg::ray_in_t'{32'h1, 32'h2, 32'h0, 32'h4, 32'h5, 32'hFFFF_FFFF});
        send_ray(rfrt_pkg::ray_in_t'{32'h1, 32'h2, 32'hFFFF_FFFF, 32'h4, 32'h5,
                                     32'hFFFF_FFFF});
        send_ray(rfrt_pkg::ray_in_t'{32'h1, 32'h2, 32'h5, 32'h4, 32'h5, 32'h0});
        send_ray(rfrt_pkg::ray_in_t'{Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN});
        send_ray(rfrt_pkg::ray_in_t'{Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX});
        wait_frame_idle();

        // Back to primary through a mode word whose upper bits are set.
        write_reg(rfrt_pkg::REG_MODE, 32'hFFFF_FFFE);
        cfg_valid <= 1'b0;
        send_ray(rfrt_pkg::ray_in_t'{32'h1, 32'h2, 32'hFFFF_FFFF, 32'h4, 32'h5, 32'h6});
        send_ray(rfrt_pkg::ray_in_t'{Q_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
        send_ray(rfrt_pkg::ray_in_t'{32'h0, Q_MIN, Q_MAX, 32'h0, Q_MAX, Q_MAX});
        wait_frame_idle();

        // Random phases: fresh frame each time, alternating modes.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            mode_word    = $urandom;
            mode_word[0] = phase[0];
            program_frame(mode_word, random_coef(), random_coef(), random_coord(),
                          random_coord(), random_coord(), random_coord());
            in_calm  = (phase == 1) || (phase == 2);
            out_calm = (phase == 1);
            // The receiver holds off long enough for the pipeline to back up.
            if (phase == 2)
            begin
                hold_cycles = 400;
            end
            repeat (RAND_RAYS) send_ray(random_ray(phase[0]));
            wait_frame_idle();
        end

        if (sb.errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* ray_frame_rotate_translate.f */
src/rfrt_pkg.sv
src/rfrt_cfg_regs.sv
src/rfrt_mult_stage.sv
src/rfrt_sum_stage.sv
src/rfrt_out_stage.sv
src/ray_frame_rotate_translate.sv
test/ray_frame_rotate_translate_tb.sv
